// ===== src/srsa_pkg.sv =====
// Types, codes and helpers shared by the slot record store allocator.
// No dependencies; imported by srsa_free_map and slot_record_store_allocator.
`default_nettype none

package srsa_pkg;

  localparam int HANDLE_W = 12;
  localparam int DATA_W   = 64;
  localparam int ROLE_W   = 8;
  localparam int STATUS_W = 3;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_GET    = 2'd1;
  localparam logic [1:0] REQ_UPDATE = 2'd2;
  localparam logic [1:0] REQ_DELETE = 2'd3;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FREE       = 3'd5;

  // free map is held as words of FM_W slot bits
  localparam int FM_W  = 32;
  localparam int FM_BW = 5;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [HANDLE_W-1:0] slot_handle;
    logic [DATA_W-1:0]   rec_id;
    logic [ROLE_W-1:0]   rec_role;
    logic [DATA_W-1:0]   name_word;
    logic [DATA_W-1:0]   key_word;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] out_handle;
    logic [DATA_W-1:0]   out_id;
    logic [ROLE_W-1:0]   out_role;
    logic [DATA_W-1:0]   out_name;
    logic [DATA_W-1:0]   out_key;
  } rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] id;
    logic [ROLE_W-1:0] role;
    logic [DATA_W-1:0] name;
    logic [DATA_W-1:0] key;
  } rec_t;

  // Free map commands. During init, slot carries a map word number.
  typedef struct packed {
    logic                init;
    logic                look;
    logic                find;
    logic                take;
    logic                put_back;
    logic [HANDLE_W-1:0] slot;
  } fm_cmd_t;

  typedef struct packed {
    logic                any_free;
    logic                slot_free;
    logic [HANDLE_W-1:0] low_slot;
  } fm_stat_t;

  // Keep bytes 0..nbytes-2 up to the first zero byte, clear the rest.
  function automatic logic [DATA_W-1:0] clean_word(input logic [DATA_W-1:0] w,
                                                   input int nbytes);
    logic [DATA_W-1:0] r;
    logic              alive;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (alive && (i + 1 < nbytes) && (w[8*i +: 8] != 8'd0)) begin
        r[8*i +: 8] = w[8*i +: 8];
      end else begin
        alive = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/srsa_free_map.sv =====
// Two-level free map: a memory of FM_W-bit slot words plus a summary register
// with one bit per word. Depends on srsa_pkg.
`default_nettype none

module srsa_free_map import srsa_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  fm_cmd_t  cmd,
  output fm_stat_t stat
);

  localparam int NWORDS = (SLOTS + FM_W - 1) / FM_W;
  localparam int WI     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CW     = HANDLE_W + 1;

  logic [FM_W-1:0]   mem [NWORDS];
  logic [FM_W-1:0]   rdata;
  logic [WI-1:0]     word_q;
  logic [NWORDS-1:0] summary;

  logic [WI-1:0]     low_word;
  logic [WI-1:0]     rd_word;
  logic [WI-1:0]     cmd_word;
  logic [FM_BW-1:0]  bit_idx;
  logic [FM_BW-1:0]  low_bit;
  logic [FM_W-1:0]   new_word;
  logic [FM_W-1:0]   init_mask;
  logic [CW-1:0]     init_base;
  logic              init_ok;
  logic              wr_en;
  logic [WI-1:0]     wr_addr;
  logic [FM_W-1:0]   wr_data;

  function automatic logic [FM_BW-1:0] lowest_bit(input logic [FM_W-1:0] v);
    logic [FM_BW-1:0] r;
    r = '0;
    for (int i = FM_W - 1; i >= 0; i--) begin
      if (v[i]) r = FM_BW'(i);
    end
    return r;
  endfunction

  always_comb begin
    low_word = '0;
    for (int i = NWORDS - 1; i >= 0; i--) begin
      if (summary[i]) low_word = WI'(i);
    end
  end

  assign cmd_word = cmd.slot[FM_BW +: WI];
  assign bit_idx  = cmd.slot[FM_BW-1:0];
  assign rd_word  = cmd.find ? low_word : cmd_word;
  assign low_bit  = lowest_bit(rdata);

  always_comb begin
    new_word = rdata;
    if (cmd.take)     new_word[bit_idx] = 1'b0;
    if (cmd.put_back) new_word[bit_idx] = 1'b1;
  end

  // only slots below SLOTS start out free
  assign init_base = CW'({cmd.slot[WI-1:0], {FM_BW{1'b0}}});
  assign init_ok   = cmd.slot < HANDLE_W'(NWORDS);
  always_comb begin
    for (int b = 0; b < FM_W; b++) begin
      init_mask[b] = (init_base + CW'(b)) < CW'(SLOTS);
    end
  end

  assign wr_en   = (cmd.init && init_ok) || cmd.take || cmd.put_back;
  assign wr_addr = cmd.init ? cmd.slot[WI-1:0] : cmd_word;
  assign wr_data = cmd.init ? init_mask : new_word;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.look) begin
      rdata  <= mem[rd_word];
      word_q <= rd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      summary <= '1;
    end else if (cmd.take || cmd.put_back) begin
      summary[cmd_word] <= |new_word;
    end
  end

  assign stat.any_free  = |summary;
  assign stat.slot_free = rdata[bit_idx];
  assign stat.low_slot  = HANDLE_W'({word_q, low_bit});

  a_take_free: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> stat.slot_free)
    else $error("slot taken that the map does not show free");

  a_release_used: assert property (@(posedge clk) disable iff (rst)
    cmd.put_back |-> !stat.slot_free)
    else $error("slot released that the map already shows free");

  a_init_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.init |-> !(cmd.look || cmd.take || cmd.put_back))
    else $error("map access during init sweep");

endmodule

`default_nettype wire

// ===== src/slot_record_store_allocator.sv =====
// Record slot store with lowest-free-slot allocation: top level, record memory
// and request sequencer. Depends on srsa_pkg and srsa_free_map.
//
// Usage: requests come in on req (req_valid / req_stall), one response word per
// request goes out on rsp (rsp_valid / rsp_stall). Add places the record in
// the lowest free slot and returns handle = slot + 1; get, update and delete
// address a slot by handle. Status tells ok, invalid record, not found, bad
// handle, full or already free.
// Timing: a request word is taken in S_IDLE, the record memory and free-map word
// are read in S_READ, and in S_EXEC the result is written back and registered;
// S_EXEC waits while a held response is stalled. No new request is taken until
// the last one is through, as the read-modify-write of the slot memory requires.
// Reset: a sweep over all SLOTS slots zeroes the record memory and marks every
// slot free; req_stall stays high meanwhile.
// A stalled response holds; the next request may be taken while it waits, but
// its result is held back until the waiting word has gone.
`default_nettype none

module slot_record_store_allocator import srsa_pkg::*; #(
  parameter int SLOTS      = 1024,
  parameter int NAME_BYTES = 8,
  parameter int KEY_BYTES  = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int SW = $clog2(SLOTS);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC} state_t;

  state_t        state;
  logic [SW-1:0] clr_cnt;
  req_t          cur;

  rec_t          rec_mem [SLOTS];
  rec_t          rec_rd;
  logic          rec_we;
  logic [SW-1:0] rec_wa;
  rec_t          rec_wd;

  fm_cmd_t       fm_cmd;
  fm_stat_t      fm_stat;

  logic          handle_ok;
  logic [SW-1:0] slot_idx;
  logic          rec_bad;
  logic          commit;
  logic          take;
  logic          release_slot;
  rsp_t          rsp_next;
  rec_t          new_rec;

  assign handle_ok = (cur.slot_handle != '0) && (cur.slot_handle <= HANDLE_W'(SLOTS));
  assign slot_idx  = handle_ok ? SW'(cur.slot_handle - HANDLE_W'(1)) : '0;
  assign rec_bad   = (cur.name_word[8*(NAME_BYTES-1) +: 8] != 8'd0) ||
                     (cur.key_word[8*(KEY_BYTES-1) +: 8] != 8'd0);
  assign commit    = (state == S_EXEC) && !(rsp_valid && rsp_stall);
  assign req_stall = (state != S_IDLE);

  always_comb begin
    new_rec.id   = cur.rec_id;
    new_rec.role = cur.rec_role;
    new_rec.name = clean_word(cur.name_word, NAME_BYTES);
    new_rec.key  = clean_word(cur.key_word, KEY_BYTES);
  end

  // result and write-back of the request in S_EXEC, and the clearing write in S_CLEAR
  always_comb begin
    rsp_next     = '0;
    take         = 1'b0;
    release_slot = 1'b0;
    rec_we       = 1'b0;
    rec_wa       = slot_idx;
    rec_wd       = new_rec;
    case (cur.req_type)
      REQ_ADD: begin
        if (rec_bad) begin
          rsp_next.status = ST_INVALID;
        end else if (!fm_stat.any_free) begin
          rsp_next.status = ST_FULL;
        end else begin
          rsp_next.out_handle = fm_stat.low_slot + HANDLE_W'(1);
          take   = 1'b1;
          rec_we = 1'b1;
          rec_wa = SW'(fm_stat.low_slot);
        end
      end
      REQ_GET: begin
        if (!handle_ok) begin
          rsp_next.status = ST_BAD_HANDLE;
        end else if (rec_rd.id == '0) begin
          rsp_next.status = ST_NOT_FOUND;
        end else begin
          rsp_next.out_id   = rec_rd.id;
          rsp_next.out_role = rec_rd.role;
          rsp_next.out_name = rec_rd.name;
          rsp_next.out_key  = rec_rd.key;
        end
      end
      REQ_UPDATE: begin
        if (rec_bad) begin
          rsp_next.status = ST_INVALID;
        end else if (!handle_ok) begin
          rsp_next.status = ST_BAD_HANDLE;
        end else if (rec_rd.id == '0) begin
          rsp_next.status = ST_NOT_FOUND;
        end else begin
          rec_we = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (!handle_ok) begin
          rsp_next.status = ST_BAD_HANDLE;
        end else if (fm_stat.slot_free) begin
          rsp_next.status = ST_FREE;
        end else begin
          release_slot = 1'b1;
          rec_we       = 1'b1;
          rec_wd       = '0;
        end
      end
      default: begin
        rsp_next.status = ST_OK;
      end
    endcase
    if (!commit) begin
      take         = 1'b0;
      release_slot = 1'b0;
      rec_we       = 1'b0;
    end
    if (state == S_CLEAR) begin
      rec_we = 1'b1;
      rec_wa = clr_cnt;
      rec_wd = '0;
    end
  end

  always_comb begin
    fm_cmd = '0;
    case (state)
      S_CLEAR: begin
        fm_cmd.init = 1'b1;
        fm_cmd.slot = HANDLE_W'(clr_cnt);
      end
      S_READ: begin
        fm_cmd.look = 1'b1;
        fm_cmd.find = (cur.req_type == REQ_ADD);
        fm_cmd.slot = HANDLE_W'(slot_idx);
      end
      S_EXEC: begin
        fm_cmd.take     = take;
        fm_cmd.put_back = release_slot;
        fm_cmd.slot     = (cur.req_type == REQ_ADD) ? fm_stat.low_slot
                                                    : HANDLE_W'(slot_idx);
      end
      default: begin
        fm_cmd = '0;
      end
    endcase
  end

  srsa_free_map #(
    .SLOTS(SLOTS)
  ) u_free_map (
    .clk  (clk),
    .rst  (rst),
    .cmd  (fm_cmd),
    .stat (fm_stat)
  );

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (state == S_READ) rec_rd <= rec_mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + SW'(1);
          if (clr_cnt == SW'(SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (commit) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (commit) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_commit_rsp: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp_valid)
    else $error("request finished without a response word");

  a_handle_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.out_handle != '0)) |->
      ((rsp.status == ST_OK) && (rsp.out_handle <= HANDLE_W'(SLOTS))))
    else $error("handle returned out of range or with error status");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_OK)) |->
      ((rsp.out_handle == '0) && (rsp.out_id == '0)))
    else $error("error response carries data");

endmodule

`default_nettype wire
